[rtl/core/sttc_pkg.sv]
// Shared types, codes and helpers for the square tile transform classifier.
// No dependencies; imported by sttc_dp, sttc_ctrl and the top level.
`timescale 1ns / 1ps

package sttc_pkg;

    localparam int MAX_SIDE_DEF = 16;
    localparam int SIDE_W       = 5;
    localparam int OP_W         = 2;
    localparam int CODE_W       = 3;
    localparam int CAND_W       = 3;

    // op codes
    localparam logic [OP_W-1:0] OP_LOAD_SRC = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_TGT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

    // candidate transforms, tried in this order
    localparam logic [CAND_W-1:0] CAND_ROT90     = 3'd0;
    localparam logic [CAND_W-1:0] CAND_ROT180    = 3'd1;
    localparam logic [CAND_W-1:0] CAND_ROT270    = 3'd2;
    localparam logic [CAND_W-1:0] CAND_MIRROR    = 3'd3;
    localparam logic [CAND_W-1:0] CAND_MIR_R90   = 3'd4;
    localparam logic [CAND_W-1:0] CAND_MIR_R180  = 3'd5;
    localparam logic [CAND_W-1:0] CAND_MIR_R270  = 3'd6;
    localparam logic [CAND_W-1:0] CAND_IDENTITY  = 3'd7;

    // reported transform codes
    localparam logic [CODE_W-1:0] CODE_ROT90    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ROT180   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ROT270   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MIRROR   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_MIR_ROT  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_IDENTITY = 3'd5;
    localparam logic [CODE_W-1:0] CODE_NONE     = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch side, clear counters and fail flags
        logic issue;   // read one cell pair and advance the walk
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic              last_issue;  // walk sits on its final cell
        logic [CODE_W-1:0] code;        // code from the fail flags
    } t_dp_sts;

    // First candidate without a mismatch wins.
    function automatic logic [CODE_W-1:0] pick_code(input logic [7:0] fail);
        logic [CODE_W-1:0] code;
        code = CODE_NONE;
        priority if (!fail[CAND_ROT90])     code = CODE_ROT90;
        else if (!fail[CAND_ROT180])        code = CODE_ROT180;
        else if (!fail[CAND_ROT270])        code = CODE_ROT270;
        else if (!fail[CAND_MIRROR])        code = CODE_MIRROR;
        else if (!fail[CAND_MIR_R90])       code = CODE_MIR_ROT;
        else if (!fail[CAND_MIR_R180])      code = CODE_MIR_ROT;
        else if (!fail[CAND_MIR_R270])      code = CODE_MIR_ROT;
        else if (!fail[CAND_IDENTITY])      code = CODE_IDENTITY;
        else                                code = CODE_NONE;
        return code;
    endfunction

endpackage

[rtl/core/sttc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sttc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sttc_dp.sv]
// Datapath: source and target grid RAMs, cell walk counters, address mapping
// and per-candidate mismatch flags. Depends on sttc_pkg and sttc_ram.
`timescale 1ns / 1ps

module sttc_dp #(
    parameter int MAX_SIDE = sttc_pkg::MAX_SIDE_DEF,
    parameter int IW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sttc_pkg::t_dp_cmd           i_cmd,
    output sttc_pkg::t_dp_sts           o_sts,
    input  logic [sttc_pkg::SIDE_W-1:0] i_side,
    input  logic                        i_we_src,
    input  logic                        i_we_tgt,
    input  logic [IW-1:0]               i_wr_row,
    input  logic [IW-1:0]               i_wr_col,
    input  logic                        i_wr_bit
);

    import sttc_pkg::*;

    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    logic [IW-1:0]     r_nm1;
    logic [CAND_W-1:0] r_t;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic [CAND_W-1:0] r_cmp_t;
    logic              r_cmp_vld;
    logic [7:0]        r_fail;

    logic [IW-1:0]     mi, mj, src_r, src_c;
    logic [6:0]        side_w;
    logic [IW-1:0]     n_nm1;
    logic              i_end, j_end;
    logic              src_q, tgt_q;

    // clamp side to 1..MAX_SIDE
    always_comb begin
        side_w = 7'(i_side);
        if (side_w == 7'd0) begin
            n_nm1 = '0;
        end else if (side_w > 7'(MAX_SIDE)) begin
            n_nm1 = IW'(MAX_SIDE - 1);
        end else begin
            n_nm1 = IW'(side_w - 7'd1);
        end
    end

    // source cell feeding target cell (i,j)
    always_comb begin
        mi = r_nm1 - r_i;
        mj = r_nm1 - r_j;
        unique case (r_t)
            CAND_ROT90:    begin src_r = mj;  src_c = r_i; end
            CAND_ROT180:   begin src_r = mi;  src_c = mj;  end
            CAND_ROT270:   begin src_r = r_j; src_c = mi;  end
            CAND_MIRROR:   begin src_r = r_i; src_c = mj;  end
            CAND_MIR_R90:  begin src_r = mj;  src_c = mi;  end
            CAND_MIR_R180: begin src_r = mi;  src_c = r_j; end
            CAND_MIR_R270: begin src_r = r_j; src_c = r_i; end
            CAND_IDENTITY: begin src_r = r_i; src_c = r_j; end
            default:       begin src_r = r_i; src_c = r_j; end
        endcase
    end

    assign j_end = (r_j == r_nm1);
    assign i_end = (r_i == r_nm1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_nm1 <= n_nm1;
            r_t   <= '0;
            r_i   <= '0;
            r_j   <= '0;
        end else if (i_cmd.issue) begin
            if (j_end) begin
                r_j <= '0;
                if (i_end) begin
                    r_i <= '0;
                    r_t <= r_t + CAND_W'(1);
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end else begin
                r_j <= r_j + IW'(1);
            end
        end
        r_cmp_t <= r_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_fail    <= '0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_fail <= '0;
            end else if (r_cmp_vld && (src_q != tgt_q)) begin
                r_fail[r_cmp_t] <= 1'b1;
            end
        end
    end

    sttc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (i_we_src),
        .i_waddr ({i_wr_row, i_wr_col}),
        .i_wdata (i_wr_bit),
        .i_raddr ({src_r, src_c}),
        .o_rdata (src_q)
    );

    sttc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (i_we_tgt),
        .i_waddr ({i_wr_row, i_wr_col}),
        .i_wdata (i_wr_bit),
        .i_raddr ({r_i, r_j}),
        .o_rdata (tgt_q)
    );

    assign o_sts.last_issue = (r_t == CAND_IDENTITY) && i_end && j_end;
    assign o_sts.code       = pick_code(r_fail);

endmodule

[rtl/core/sttc_ctrl.sv]
// Controller: sequences a classify request through the cell walk and hands
// the code to the output register. Depends on sttc_pkg.
`timescale 1ns / 1ps

module sttc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_classify,  // classify item accepted
    input  logic              i_out_free,  // output register can load
    input  sttc_pkg::t_dp_sts i_sts,
    output sttc_pkg::t_dp_cmd o_cmd,
    output logic              o_idle,
    output logic              o_out_load
);

    import sttc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.start = 1'b0;
        o_cmd.issue = 1'b0;
        o_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_classify) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;  // last compare lands this cycle
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

[rtl/core/square_tile_transform_classifier_unit.sv]
// Square tile transform classifier, top level.
// Load items are accepted one per cycle, back to back, while idle.
// Classify walks all 8 candidates over n*n cells (n = clamped side), one cell at a
// time, set by the one read port of each grid RAM. The code then waits for a free
// output slot, and no new item is taken until the controller is back in idle.
// Synchronous active-low reset: controller idle, output empty, side = 1; grids undefined.
`timescale 1ns / 1ps

module square_tile_transform_classifier_unit #(
    parameter int MAX_SIDE = sttc_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config: side register
    input  logic                        i_cfg_we,
    input  logic [sttc_pkg::SIDE_W-1:0] i_cfg_wdata,
    // input items
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [15:0]                 i_s_tdata,  // row[3:0], col[7:4], cell_req[8]
    input  logic [1:0]                  i_s_tuser,  // op[1:0]
    // result items
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata   // transform_code[2:0]
);

    import sttc_pkg::*;

    localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic [SIDE_W-1:0] r_side;
    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_code;

    logic [OP_W-1:0]   in_op;
    logic [3:0]        in_row, in_col;
    logic              in_bit;
    logic [IW+3:0]     row_w, col_w;
    logic              accept, in_range;
    logic              we_src, we_tgt, classify;
    logic              idle, out_free, out_load;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // unpack the item
    assign in_op  = i_s_tuser;
    assign in_row = i_s_tdata[3:0];
    assign in_col = i_s_tdata[7:4];
    assign in_bit = i_s_tdata[8];

    assign row_w = (IW + 4)'(in_row);
    assign col_w = (IW + 4)'(in_col);

    // items are taken only while no classify is in progress
    assign o_s_tready = idle;
    assign accept     = i_s_tvalid && o_s_tready;

    // loads outside the store are dropped
    assign in_range = (row_w < (IW + 4)'(MAX_SIDE)) && (col_w < (IW + 4)'(MAX_SIDE));
    assign we_src   = accept && (in_op == OP_LOAD_SRC) && in_range;
    assign we_tgt   = accept && (in_op == OP_LOAD_TGT) && in_range;
    assign classify = accept && (in_op == OP_CLASSIFY);

    // output slot frees when empty or being taken
    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= SIDE_W'(1);
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_code <= sts.code;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = 8'(r_out_code);

    sttc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_classify (classify),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_out_load (out_load)
    );

    sttc_dp #(.MAX_SIDE(MAX_SIDE), .IW(IW)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_side   (r_side),
        .i_we_src (we_src),
        .i_we_tgt (we_tgt),
        .i_wr_row (row_w[IW-1:0]),
        .i_wr_col (col_w[IW-1:0]),
        .i_wr_bit (in_bit)
    );

endmodule
